// File: hdl/trbic_pkg.sv
// Package: shared constants, codes and types of the two-ring bit instruction core.
`timescale 1ns / 1ps
package trbic_pkg;

   localparam int MEM_DEPTH_DEF     = 4096;
   localparam int RING_SIZE         = 12;
   localparam int MAX_PROG_BITS_DEF = 1048576;
   localparam int PC_W              = 21;
   localparam int POS_W             = 4;
   localparam int WORD_W            = 32;
   localparam int ST_W              = 3;
   localparam int RDREQ_W           = 2;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [POS_W-1:0] RING_LAST = POS_W'(RING_SIZE - 1);

   localparam logic [ST_W-1:0] ST_RUN  = 3'd0;
   localparam logic [ST_W-1:0] ST_END  = 3'd1;
   localparam logic [ST_W-1:0] ST_OOB  = 3'd2;
   localparam logic [ST_W-1:0] ST_FULL = 3'd3;
   localparam logic [ST_W-1:0] ST_DIV0 = 3'd4;

   localparam logic [RDREQ_W-1:0] RD_NONE = 2'd0;
   localparam logic [RDREQ_W-1:0] RD_INT  = 2'd1;
   localparam logic [RDREQ_W-1:0] RD_CHAR = 2'd2;

   localparam logic REQ_BIT    = 1'b0;
   localparam logic REQ_ANSWER = 1'b1;

   // operations ring commands
   localparam logic [POS_W-1:0] OP_NOOP = 4'd0;
   localparam logic [POS_W-1:0] OP_EXIT = 4'd1;
   localparam logic [POS_W-1:0] OP_ONE  = 4'd2;
   localparam logic [POS_W-1:0] OP_ZERO = 4'd3;
   localparam logic [POS_W-1:0] OP_LOAD = 4'd4;
   localparam logic [POS_W-1:0] OP_STOR = 4'd5;
   localparam logic [POS_W-1:0] OP_PADD = 4'd6;
   localparam logic [POS_W-1:0] OP_DADD = 4'd7;
   localparam logic [POS_W-1:0] OP_LAND = 4'd8;
   localparam logic [POS_W-1:0] OP_IF   = 4'd9;
   localparam logic [POS_W-1:0] OP_INTIO = 4'd10;
   localparam logic [POS_W-1:0] OP_ASCIO = 4'd11;

   // math ring commands
   localparam logic [POS_W-1:0] MA_NOOP = 4'd0;
   localparam logic [POS_W-1:0] MA_LOAD = 4'd1;
   localparam logic [POS_W-1:0] MA_STOR = 4'd2;
   localparam logic [POS_W-1:0] MA_ADD  = 4'd3;
   localparam logic [POS_W-1:0] MA_MULT = 4'd4;
   localparam logic [POS_W-1:0] MA_DIV  = 4'd5;
   localparam logic [POS_W-1:0] MA_ZERO = 4'd6;
   localparam logic [POS_W-1:0] MA_LT   = 4'd7;
   localparam logic [POS_W-1:0] MA_GT   = 4'd8;
   localparam logic [POS_W-1:0] MA_EQ   = 4'd9;
   localparam logic [POS_W-1:0] MA_NOT  = 4'd10;
   localparam logic [POS_W-1:0] MA_NEG  = 4'd11;

   typedef struct packed {
      logic              req_type;
      logic              prog_bit;
      logic [WORD_W-1:0] read_data;
   } req_type_type;

   typedef struct packed {
      logic [PC_W-1:0]    next_pc;
      logic [ST_W-1:0]    status;
      logic [RDREQ_W-1:0] read_request;
      logic               write_valid;
      logic               write_kind;
      logic [WORD_W-1:0]  write_value;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic              answer;
      logic              prog_bit;
      logic [WORD_W-1:0] read_data;
   } item_type;

   function automatic logic [POS_W-1:0] turn(input logic [POS_W-1:0] pos, input logic ccw);
      logic [POS_W-1:0] r;
      if (!ccw) r = (pos >= RING_LAST) ? '0 : pos + 1'b1;
      else      r = (pos == '0 || pos > RING_LAST) ? RING_LAST : pos - 1'b1;
      return r;
   endfunction

endpackage

// File: hdl/trbic_if.sv
// Interfaces: valid/ready channel for requests and responses.
`timescale 1ns / 1ps
interface trbic_req_if;
   import trbic_pkg::*;
   logic         valid;
   logic         ready;
   req_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface trbic_rsp_if;
   import trbic_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/trbic_front.sv
// Front end: accept requests, classify them and queue them for execution.
`timescale 1ns / 1ps
module trbic_front (
   input  logic                  clock,
   input  logic                  reset,
   trbic_req_if.sink             req,
   output logic                  q_valid,
   output trbic_pkg::item_type   q_item,
   input  logic                  q_pop
);
   import trbic_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   item_type          slot_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              push;
   item_type          cls;

   always_comb begin
      cls.answer    = (req.payload.req_type == REQ_ANSWER);
      cls.prog_bit  = req.payload.prog_bit;
      cls.read_data = req.payload.read_data;
   end

   assign req.ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (q_pop) rd_in = (rd_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (push && !q_pop) cnt_in = cnt_ff + 1'b1;
      else if (!push && q_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= cls;
   end

endmodule

// File: hdl/trbic_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module trbic_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [trbic_pkg::WORD_W-1:0] dividend,
   input  logic [trbic_pkg::WORD_W-1:0] divisor,
   output logic                       done,
   output logic [trbic_pkg::WORD_W-1:0] quotient
);
   import trbic_pkg::*;

   localparam int CW = $clog2(WORD_W + 1);

   logic [WORD_W-1:0] q_ff, q_in, d_ff, d_in;
   logic [WORD_W:0]   r_ff, r_in;
   logic              neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WORD_W:0]   trial;
   logic [WORD_W-1:0] a_mag, b_mag;

   assign a_mag = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
   assign b_mag = divisor[WORD_W-1]  ? (~divisor + 1'b1)  : divisor;
   assign trial = {r_ff[WORD_W-1:0], q_ff[WORD_W-1]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; d_in = d_ff; r_in = r_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      if (start) begin
         q_in = a_mag; d_in = b_mag; r_in = '0;
         neg_in = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         busy_in = 1'b1; cnt_in = CW'(WORD_W);
      end else if (busy_ff) begin
         if (!trial[WORD_W]) begin
            r_in = trial;
            q_in = {q_ff[WORD_W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[WORD_W-1:0], q_ff[WORD_W-1]};
            q_in = {q_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~q_ff + 1'b1) : q_ff;

endmodule

// File: hdl/trbic_back.sv
// Back end: ring machine, data store and result register.
`timescale 1ns / 1ps
module trbic_back #(
   parameter int MEM_DEPTH     = trbic_pkg::MEM_DEPTH_DEF,
   parameter int MAX_PROG_BITS = trbic_pkg::MAX_PROG_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [trbic_pkg::PC_W-1:0] csr_wdata,
   input  logic                      q_valid,
   input  trbic_pkg::item_type       q_item,
   output logic                      q_pop,
   trbic_rsp_if.source               rsp
);
   import trbic_pkg::*;

   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int DPW = AW + 1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_EXEC  = 7'b0001000,
      S_MUL   = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type         st_ff, st_in;
   logic [WORD_W-1:0] mem [MEM_DEPTH];
   logic [WORD_W-1:0] rdata_ff;
   logic [AW-1:0]     clr_ff, clr_in;

   logic [PC_W-1:0]   plen_ff, pc_ff, pc_in;
   logic [POS_W-1:0]  opos_ff, opos_in, mpos_ff, mpos_in;
   logic              occw_ff, occw_in, mccw_ff, mccw_in, mcur_ff, mcur_in, pz_ff, pz_in;
   logic [WORD_W-1:0] oval_ff, oval_in, mval_ff, mval_in;
   logic [DPW-1:0]    dp_ff, dp_in;
   logic [ST_W-1:0]   rst_ff, rst_in;
   logic [RDREQ_W-1:0] pend_ff, pend_in;
   logic [WORD_W-1:0] prod_ff;
   rsp_type           out_ff, out_in;
   logic              ov_ff, ov_in;

   logic              we;
   logic [AW-1:0]     waddr, ci;
   logic [WORD_W-1:0] wdata;
   logic              pcset;
   logic              div_start, div_done;
   logic [WORD_W-1:0] div_q;
   logic signed [WORD_W-1:0] smem, sval;
   logic signed [PC_W+WORD_W:0] tgt;
   logic signed [DPW+WORD_W:0]  dtgt;
   logic [WORD_W-1:0] wv_value;
   logic              wv_valid, wv_kind;
   logic              finish;

   assign ci   = (dp_ff < DPW'(MEM_DEPTH)) ? dp_ff[AW-1:0] : '0;
   assign smem = rdata_ff;

   trbic_div u_div (
      .clock, .reset, .start(div_start), .dividend(mval_ff), .divisor(rdata_ff),
      .done(div_done), .quotient(div_q)
   );

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[ci];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mval_ff * rdata_ff;
   end

   assign rsp.valid   = ov_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      st_in = st_ff; clr_in = clr_ff;
      pc_in = pc_ff; opos_in = opos_ff; mpos_in = mpos_ff;
      occw_in = occw_ff; mccw_in = mccw_ff; mcur_in = mcur_ff; pz_in = pz_ff;
      oval_in = oval_ff; mval_in = mval_ff; dp_in = dp_ff;
      rst_in = rst_ff; pend_in = pend_ff;
      out_in = out_ff; ov_in = ov_ff;
      we = 1'b0; waddr = ci; wdata = '0;
      q_pop = 1'b0; div_start = 1'b0; pcset = 1'b0; finish = 1'b0;
      wv_valid = 1'b0; wv_kind = 1'b0; wv_value = '0;
      sval = mcur_ff ? mval_ff : oval_ff;
      tgt  = $signed({1'b0, pc_ff}) + sval;
      dtgt = $signed({1'b0, dp_ff}) + sval;
      if (ov_ff && rsp.ready) ov_in = 1'b0;

      case (st_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = clr_ff; wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MEM_DEPTH - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid && !(ov_ff && !rsp.ready)) begin
               if (rst_ff != ST_RUN) begin
                  q_pop = 1'b1; finish = 1'b1;
               end else if (pend_ff != RD_NONE) begin
                  q_pop = 1'b1; finish = 1'b1;
                  if (q_item.answer) begin
                     we = 1'b1; wdata = q_item.read_data; pend_in = RD_NONE;
                  end
               end else if (q_item.answer) begin
                  q_pop = 1'b1; finish = 1'b1;
               end else if (pc_ff >= plen_ff) begin
                  q_pop = 1'b1; finish = 1'b1; rst_in = ST_END;
               end else begin
                  st_in = S_READ;
               end
            end
         end
         S_READ: st_in = S_EXEC;   // cell read data now registered
         S_MUL: st_in = S_OUT;
         S_DIV: if (div_done) st_in = S_OUT;
         S_OUT: begin
            q_pop = 1'b1; finish = 1'b1; st_in = S_IDLE;
            mval_in = (mpos_ff == MA_MULT) ? prod_ff : div_q;
            pz_in = 1'b0; mcur_in = 1'b0; mccw_in = ~mccw_ff;
            pc_in = pc_ff + 1'b1;
            if (pc_in >= plen_ff) rst_in = ST_END;
         end
         S_EXEC: begin
            q_pop = 1'b1; finish = 1'b1; st_in = S_IDLE;
            if (q_item.prog_bit) begin
               if (mcur_ff) mpos_in = turn(mpos_ff, mccw_ff);
               else         opos_in = turn(opos_ff, occw_ff);
               pz_in = 1'b0;
            end else begin
               if (mcur_ff) mccw_in = ~mccw_ff; else occw_in = ~occw_ff;
               if (!pz_ff) pz_in = 1'b1;
               else begin
                  pz_in = 1'b0;
                  if (mcur_ff) begin
                     case (mpos_ff)
                        MA_NOOP: ;
                        MA_LOAD: mval_in = rdata_ff;
                        MA_STOR: begin we = 1'b1; wdata = mval_ff; end
                        MA_ADD:  mval_in = mval_ff + rdata_ff;
                        MA_MULT: begin
                           q_pop = 1'b0; finish = 1'b0; st_in = S_MUL;
                           pz_in = pz_ff; mccw_in = mccw_ff;
                        end
                        MA_DIV: begin
                           if (rdata_ff == '0) rst_in = ST_DIV0;
                           else begin
                              q_pop = 1'b0; finish = 1'b0; st_in = S_DIV;
                              div_start = 1'b1; pz_in = pz_ff; mccw_in = mccw_ff;
                           end
                        end
                        MA_ZERO: mval_in = '0;
                        MA_LT:   mval_in = WORD_W'(sval < smem);
                        MA_GT:   mval_in = WORD_W'(sval > smem);
                        MA_EQ:   mval_in = WORD_W'(sval == smem);
                        MA_NOT:  mval_in = WORD_W'(mval_ff == '0);
                        MA_NEG:  mval_in = ~mval_ff + 1'b1;
                        default: rst_in = ST_END;
                     endcase
                  end else begin
                     case (opos_ff)
                        OP_NOOP: ;
                        OP_ONE:  oval_in = WORD_W'(1);
                        OP_ZERO: oval_in = '0;
                        OP_LOAD: oval_in = rdata_ff;
                        OP_STOR: begin we = 1'b1; wdata = oval_ff; end
                        OP_DADD: begin
                           if (dtgt < 0) rst_in = ST_OOB;
                           else if (dtgt >= MEM_DEPTH) rst_in = ST_FULL;
                           else dp_in = DPW'(dtgt);
                        end
                        OP_LAND: oval_in = WORD_W'(rdata_ff != '0 && oval_ff != '0);
                        OP_PADD, OP_IF: begin
                           if (!(opos_ff == OP_IF && rdata_ff == '0)) begin
                              if (tgt < 0 || tgt >= $signed({1'b0, plen_ff})) rst_in = ST_OOB;
                              else begin pc_in = PC_W'(tgt); pcset = 1'b1; end
                           end
                        end
                        OP_INTIO, OP_ASCIO: begin
                           if (oval_ff == '0) pend_in = (opos_ff == OP_INTIO) ? RD_INT : RD_CHAR;
                           else begin
                              wv_valid = 1'b1;
                              wv_kind  = (opos_ff == OP_ASCIO);
                              wv_value = rdata_ff;
                           end
                        end
                        default: rst_in = ST_END;
                     endcase
                  end
                  if (st_in == S_IDLE) begin
                     if (rst_in != ST_RUN) begin
                        wv_valid = 1'b0; wv_kind = 1'b0; wv_value = '0;
                        mccw_in = mccw_ff; occw_in = occw_ff; // failed command: keep
                        if (mcur_ff) mccw_in = ~mccw_ff; else occw_in = ~occw_ff;
                     end else mcur_in = ~mcur_ff;
                  end
               end
            end
            if (st_in == S_IDLE && rst_in == ST_RUN) begin
               if (!pcset) pc_in = pc_ff + 1'b1;
               if (pend_in == RD_NONE && pc_in >= plen_ff) rst_in = ST_END;
            end
         end
         default: st_in = S_IDLE;
      endcase

      if (finish) begin
         ov_in = 1'b1;
         out_in.next_pc      = pc_in;
         out_in.status       = rst_in;
         out_in.read_request = (rst_in == ST_RUN) ? pend_in : RD_NONE;
         out_in.write_valid  = wv_valid;
         out_in.write_kind   = wv_kind;
         out_in.write_value  = wv_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR; clr_ff <= '0;
         plen_ff <= '0; pc_ff <= '0;
         opos_ff <= '0; mpos_ff <= '0; occw_ff <= 1'b0; mccw_ff <= 1'b0;
         mcur_ff <= 1'b0; pz_ff <= 1'b0; oval_ff <= '0; mval_ff <= '0;
         dp_ff <= '0; rst_ff <= ST_RUN; pend_ff <= RD_NONE; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in;
         if (csr_we)
            plen_ff <= (csr_wdata > PC_W'(MAX_PROG_BITS)) ? PC_W'(MAX_PROG_BITS) : csr_wdata;
         pc_ff <= pc_in;
         opos_ff <= opos_in; mpos_ff <= mpos_in; occw_ff <= occw_in; mccw_ff <= mccw_in;
         mcur_ff <= mcur_in; pz_ff <= pz_in; oval_ff <= oval_in; mval_ff <= mval_in;
         dp_ff <= dp_in; rst_ff <= rst_in; pend_ff <= pend_in; ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// File: hdl/two_ring_bit_instruction_core.sv
// Top level of the two-ring bit instruction core.
`timescale 1ns / 1ps
// Usage:
//  req channel carries one request: a program bit (req_type 0) fetched at the
//  last reported next_pc, or an answer (req_type 1) to a pending read.
//  rsp channel returns exactly one response per request: next program counter,
//  run status, read request, and an optional integer or character write.
//  csr_we/csr_wdata set the program length; write it only while idle.
// Sequence:
//  A request is queued by the front end, then the back end reads the data
//  cell (S_READ) and executes (S_EXEC), one request at a time in the back
//  end. Multiply then passes S_MUL (registered product) and S_OUT; divide
//  waits in S_DIV for the divider, one quotient bit per cycle, then S_OUT.
//  Answers, halted inputs, inputs while a read is pending and end-of-program
//  checks finish in S_IDLE, without a cell read.
// Reset:
//  After reset the data store is swept to zero, one cell per cycle, in
//  S_CLEAR; requests queue but are not executed meanwhile.
// Stall:
//  A response waits in the output register; the back end stops, the two-entry
//  queue fills and then req ready drops.
module two_ring_bit_instruction_core #(
   parameter int MEM_DEPTH     = trbic_pkg::MEM_DEPTH_DEF,
   parameter int MAX_PROG_BITS = trbic_pkg::MAX_PROG_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   trbic_req_if.sink                  req,
   trbic_rsp_if.source                rsp,
   input  logic                       csr_we,
   input  logic [trbic_pkg::PC_W-1:0] csr_wdata
);
   import trbic_pkg::*;

   logic     q_valid, q_pop;
   item_type q_item;

   // accept and classify
   trbic_front u_front (
      .clock, .reset, .req, .q_valid, .q_item, .q_pop
   );

   // execute
   trbic_back #(.MEM_DEPTH(MEM_DEPTH), .MAX_PROG_BITS(MAX_PROG_BITS)) u_back (
      .clock, .reset, .csr_we, .csr_wdata, .q_valid, .q_item, .q_pop, .rsp
   );

endmodule

// File: hdl/trbic_checker.sv
// Checker: port-level assertions on the core, bound to the top level.
`timescale 1ns / 1ps
module trbic_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [trbic_pkg::ST_W-1:0] rsp_status,
   input logic [1:0]                 rsp_rdreq,
   input logic                       rsp_wv,
   input logic                       rsp_wk,
   input logic [31:0]                rsp_wval
);
   import trbic_pkg::*;

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped under stall");
   a_halt_noread: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_RUN |-> rsp_rdreq == RD_NONE)
      else $error("read requested while halted");
   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wv |-> !rsp_wk && rsp_wval == '0)
      else $error("write fields set without write");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_DIV0)
      else $error("bad status");
endmodule

bind two_ring_bit_instruction_core trbic_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.payload.status), .rsp_rdreq(rsp.payload.read_request),
   .rsp_wv(rsp.payload.write_valid), .rsp_wk(rsp.payload.write_kind),
   .rsp_wval(rsp.payload.write_value)
);
